@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL; both expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cde_pkg.sv @@
package cde_pkg;

    localparam int VALUE_W   = 32;
    localparam int AMT_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 5;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [3:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_REAR  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_REAR   = 4'd3,
        OP_PEEK_FRONT = 4'd4,
        OP_PEEK_REAR  = 4'd5,
        OP_WALK_FWD   = 4'd6,
        OP_WALK_BACK  = 4'd7,
        OP_ROTATE     = 4'd8,
        OP_NOP        = 4'd15
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode              op;
        logic [VALUE_W-1:0]   value;
        logic [AMT_W-1:0]     amount;
    } t_cmd;

endpackage

@@ hdl/cde_front.sv @@
module cde_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [3:0]                   i_operation,
    input  logic [cde_pkg::VALUE_W-1:0]  i_push_value,
    input  logic [cde_pkg::AMT_W-1:0]    i_rotate_amount,
    output logic                         o_cmd_valid,
    output cde_pkg::t_cmd                o_cmd,
    input  logic                         i_cmd_ready
);
    import cde_pkg::*;

    logic    r_valid;
    t_cmd    r_cmd;
    t_opcode w_op;
    logic    w_accept;

    // Fold every unused operation code into a no-op
    always_comb begin
        if (i_operation > 4'(OP_ROTATE)) begin
            w_op = OP_NOP;
        end else begin
            w_op = t_opcode'(i_operation);
        end
    end

    // Hold the decoded command until the queue takes it
    assign o_busy   = r_valid && !i_cmd_ready;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.op     <= w_op;
            r_cmd.value  <= i_push_value;
            r_cmd.amount <= i_rotate_amount;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

@@ hdl/cde_cmd_fifo.sv @@
module cde_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  cde_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output cde_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);
    import cde_pkg::*;

    localparam int Q_AW = $clog2(Q_DEPTH);

    t_cmd            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_fill;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_fill != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    // Advance pointers and occupancy on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= Q_AW'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= Q_AW'(r_rd_ptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

@@ hdl/cde_back.sv @@
module cde_back #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  cde_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_ready,
    output logic                           o_strobe,
    output logic [cde_pkg::STATUS_W-1:0]   o_status,
    output logic [cde_pkg::VALUE_W-1:0]    o_data_out,
    output logic                           o_last,
    output logic [cde_pkg::ENTRIES_W-1:0]  o_entries
);
    import cde_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int BW     = $clog2(AMT_W);
    localparam int EXT_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CEXT_W = (CW > ENTRIES_W) ? CW : ENTRIES_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_WALK = 5'b00100,
        S_DIV  = 5'b01000,
        S_ROT  = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : AW'(i - 1'b1);
    endfunction

    // Ring storage and its registered read port
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_wr_en;

    t_state           r_state,  n_state;
    logic [AW-1:0]    r_front,  n_front;
    logic [AW-1:0]    r_rear,   n_rear;
    logic [CW-1:0]    r_count,  n_count;
    t_opcode          r_op,     n_op;
    logic [AW-1:0]    r_idx,    n_idx;
    logic [CW-1:0]    r_left,   n_left;
    logic [CW-1:0]    r_rem,    n_rem;
    logic [AMT_W-1:0] r_dvd,    n_dvd;
    logic             r_neg,    n_neg;
    logic [BW-1:0]    r_bitcnt, n_bitcnt;

    logic             r_strobe, n_strobe;
    t_status          r_status, n_status;
    logic [VALUE_W-1:0] r_data, n_data;
    logic             r_last,   n_last;
    logic [ENTRIES_W-1:0] r_entries;

    logic [EXT_W-1:0]      w_rd_ext;
    logic [VALUE_W-1:0]    w_rd_word;
    logic [EXT_W-1:0]      w_push_ext;
    logic [DATA_WIDTH-1:0] w_push_data;
    logic [CEXT_W-1:0]     w_cnt_ext;
    logic [CW:0]           w_trial;
    logic                  w_ge;
    logic [CW-1:0]         w_rem_nx;
    logic [CW-1:0]         w_steps;
    logic                  w_full;
    logic                  w_empty;

    assign w_rd_ext    = EXT_W'(r_rd_data);
    assign w_rd_word   = w_rd_ext[VALUE_W-1:0];
    assign w_push_ext  = EXT_W'(i_cmd.value);
    assign w_push_data = w_push_ext[DATA_WIDTH-1:0];
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);

    // One restoring step of the rotation count reduction
    assign w_trial  = {r_rem, r_dvd[AMT_W-1]};
    assign w_ge     = (w_trial >= {1'b0, r_count});
    assign w_rem_nx = w_ge ? CW'(w_trial - {1'b0, r_count}) : CW'(w_trial);
    assign w_steps  = (r_neg && (w_rem_nx != '0)) ? CW'(r_count - w_rem_nx) : w_rem_nx;

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_rear      = r_rear;
        n_count     = r_count;
        n_op        = r_op;
        n_idx       = r_idx;
        n_left      = r_left;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_neg       = r_neg;
        n_bitcnt    = r_bitcnt;
        n_strobe    = 1'b0;
        n_status    = ST_OK;
        n_data      = '0;
        n_last      = 1'b1;
        w_rd_addr   = r_front;
        w_wr_addr   = r_front;
        w_wr_data   = w_push_data;
        w_wr_en     = 1'b0;
        o_cmd_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_op = i_cmd.op;
                    case (i_cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            n_strobe = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = CW'(r_count + 1'b1);
                                w_wr_en = 1'b1;
                                if (i_cmd.op == OP_PUSH_FRONT) begin
                                    n_front   = idx_inc(r_front);
                                    w_wr_addr = n_front;
                                end else begin
                                    n_rear    = idx_dec(r_rear);
                                    w_wr_addr = n_rear;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                // Launch the read; the result leaves from S_READ
                                if (i_cmd.op == OP_POP_FRONT || i_cmd.op == OP_PEEK_FRONT) begin
                                    w_rd_addr = r_front;
                                end else begin
                                    w_rd_addr = r_rear;
                                end
                                if (i_cmd.op == OP_POP_FRONT) begin
                                    n_count = CW'(r_count - 1'b1);
                                    n_front = idx_dec(r_front);
                                end else if (i_cmd.op == OP_POP_REAR) begin
                                    n_count = CW'(r_count - 1'b1);
                                    n_rear  = idx_inc(r_rear);
                                end
                                n_state = S_READ;
                            end
                        end
                        OP_WALK_FWD, OP_WALK_BACK: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                if (i_cmd.op == OP_WALK_FWD) begin
                                    w_rd_addr = r_front;
                                    n_idx     = idx_dec(r_front);
                                end else begin
                                    w_rd_addr = r_rear;
                                    n_idx     = idx_inc(r_rear);
                                end
                                n_left  = r_count;
                                n_state = S_WALK;
                            end
                        end
                        OP_ROTATE: begin
                            if (w_empty) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_neg    = i_cmd.amount[AMT_W-1];
                                n_dvd    = i_cmd.amount[AMT_W-1] ?
                                           AMT_W'(~i_cmd.amount + 1'b1) : i_cmd.amount;
                                n_rem    = '0;
                                n_bitcnt = '0;
                                n_state  = S_DIV;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_strobe = 1'b1;
                n_data   = w_rd_word;
                n_state  = S_IDLE;
            end

            // Emit one element per cycle while the next read is in flight
            S_WALK: begin
                n_strobe  = 1'b1;
                n_data    = w_rd_word;
                n_last    = (r_left == CW'(1));
                w_rd_addr = r_idx;
                n_idx     = (r_op == OP_WALK_FWD) ? idx_dec(r_idx) : idx_inc(r_idx);
                n_left    = CW'(r_left - 1'b1);
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end

            // Reduce the amount modulo the fill, one bit per cycle
            S_DIV: begin
                w_rd_addr = r_front;
                n_rem     = w_rem_nx;
                n_dvd     = {r_dvd[AMT_W-2:0], 1'b0};
                n_bitcnt  = BW'(r_bitcnt + 1'b1);
                if (r_bitcnt == BW'(AMT_W - 1)) begin
                    if (w_steps == '0) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_left  = w_steps;
                        n_state = S_ROT;
                    end
                end
            end

            // Move the front element behind the rear, one per cycle
            S_ROT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = idx_dec(r_rear);
                w_wr_data = r_rd_data;
                n_front   = idx_dec(r_front);
                n_rear    = idx_dec(r_rear);
                w_rd_addr = idx_dec(r_front);
                n_left    = CW'(r_left - 1'b1);
                if (r_left == CW'(1)) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cnt_ext = CEXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= AW'(DEPTH - 1);
            r_rear   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_neg     <= n_neg;
        r_bitcnt  <= n_bitcnt;
        r_status  <= n_status;
        r_data    <= n_data;
        r_last    <= n_last;
        r_entries <= w_cnt_ext[ENTRIES_W-1:0];
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_data_out = r_data;
    assign o_last     = r_last;
    assign o_entries  = r_entries;

endmodule

@@ hdl/circular_deque_engine.sv @@
// Circular double-ended queue of DEPTH words. Raise start with an operation while
// busy is low; the command is registered, queued two deep and executed by the back
// end, so start may be issued again while earlier commands still run. Results
// come out on o_strobe for exactly one cycle each and cannot be held off; a walk
// sends one result per stored element, o_last marking the final one. In the back
// end, whose ring memory has a registered read port, a push or any refused or no-op
// command finishes in S_IDLE, pop and peek wait for the read in S_READ, a walk
// streams the elements from S_WALK, and a rotation reduces the amount modulo the
// fill bit-serially in S_DIV, then moves up to fill-1 front elements behind the rear in S_ROT.
// No clearing pass after reset.
`include "assert_macros.svh"

module circular_deque_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [3:0]                     i_operation,
    input  logic [cde_pkg::VALUE_W-1:0]    i_push_value,
    input  logic signed [cde_pkg::AMT_W-1:0] i_rotate_amount,
    output logic                           o_strobe,
    output logic [cde_pkg::STATUS_W-1:0]   o_status,
    output logic [cde_pkg::VALUE_W-1:0]    o_data_out,
    output logic                           o_last,
    output logic [cde_pkg::ENTRIES_W-1:0]  o_entries
);
    import cde_pkg::*;

    localparam logic [ENTRIES_W-1:0] FULL_ENTRIES = ENTRIES_W'(DEPTH);

    logic w_front_valid;
    t_cmd w_front_cmd;
    logic w_q_ready;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_back_ready;

    // Accept and classify commands
    cde_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_operation     (i_operation),
        .i_push_value    (i_push_value),
        .i_rotate_amount (i_rotate_amount),
        .o_cmd_valid     (w_front_valid),
        .o_cmd           (w_front_cmd),
        .i_cmd_ready     (w_q_ready)
    );

    // Decouple front and back
    cde_cmd_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .i_push_cmd   (w_front_cmd),
        .o_push_ready (w_q_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_cmd    (w_q_cmd),
        .i_pop_ready  (w_back_ready)
    );

    // Execute against the ring
    cde_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_ready (w_back_ready),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_last      (o_last),
        .o_entries   (o_entries)
    );

    `CDE_ASSERT_IMPL(a_full_entries, o_strobe && (o_status == ST_FULL),
        o_entries == FULL_ENTRIES, "full status with queue not full")
    `CDE_ASSERT_IMPL(a_empty_entries, o_strobe && (o_status == ST_EMPTY),
        o_entries == '0, "empty status with stored entries")
    `CDE_ASSERT_IMPL(a_walk_ok, o_strobe && !o_last,
        o_status == ST_OK, "non-final result without ok status")
    `CDE_ASSERT_NEXT(a_accept_held, start && !busy,
        w_front_valid, "accepted command lost in front end")

endmodule

@@ tb/sv/tb_circular_deque_engine.sv @@
module tb_circular_deque_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import cde_pkg::*;

    localparam int RING_DEPTH    = 16;
    localparam int RAND_ITEMS    = 380;
    localparam int QUIET_TAIL    = 60;
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [VALUE_W-1:0]   data;
        logic                 last;
        logic [ENTRIES_W-1:0] entries;
    } deque_result_t;

    // Shadow copy of the deque; predicts the result stream of every accepted command.
    class deque_shadow;
        logic [VALUE_W-1:0] ring [RING_DEPTH];
        int unsigned        front_ix;
        int unsigned        rear_ix;
        int unsigned        fill;
        deque_result_t      pending_results [$];
        int unsigned        error_count;

        function new();
            front_ix    = RING_DEPTH - 1;
            rear_ix     = 0;
            fill        = 0;
            error_count = 0;
            foreach (ring[k]) ring[k] = '0;
        endfunction

        function void add_result(t_status st, logic [VALUE_W-1:0] data, logic last);
            deque_result_t r;
            r.status  = st;
            r.data    = data;
            r.last    = last;
            r.entries = ENTRIES_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void note_command(t_opcode op, logic [VALUE_W-1:0] value,
                                   logic signed [AMT_W-1:0] amount);
            int unsigned        ix;
            int                 steps;
            logic [VALUE_W-1:0] word;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (fill >= RING_DEPTH) begin
                        add_result(ST_FULL, '0, 1'b1);
                    end else begin
                        fill++;
                        if (op == OP_PUSH_FRONT) begin
                            front_ix = (front_ix + 1) % RING_DEPTH;
                            ring[front_ix] = value;
                        end else begin
                            rear_ix = (rear_ix + RING_DEPTH - 1) % RING_DEPTH;
                            ring[rear_ix] = value;
                        end
                        add_result(ST_OK, '0, 1'b1);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
                    if (fill == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        word = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ?
                               ring[front_ix] : ring[rear_ix];
                        if (op == OP_POP_FRONT) begin
                            fill--;
                            front_ix = (front_ix + RING_DEPTH - 1) % RING_DEPTH;
                        end else if (op == OP_POP_REAR) begin
                            fill--;
                            rear_ix = (rear_ix + 1) % RING_DEPTH;
                        end
                        add_result(ST_OK, word, 1'b1);
                    end
                end
                OP_WALK_FWD, OP_WALK_BACK: begin
                    if (fill == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        // Visit front to rear (downward) or rear to front (upward)
                        ix = (op == OP_WALK_FWD) ? front_ix : rear_ix;
                        for (int k = 0; k < fill; k++) begin
                            add_result(ST_OK, ring[ix], (k + 1) == fill);
                            ix = (op == OP_WALK_FWD) ? (ix + RING_DEPTH - 1) % RING_DEPTH
                                                     : (ix + 1) % RING_DEPTH;
                        end
                    end
                end
                OP_ROTATE: begin
                    if (fill != 0) begin
                        // Reduce the signed amount into 0..fill-1
                        steps = ((int'(amount) % int'(fill)) + int'(fill)) % int'(fill);
                        for (int k = 0; k < steps; k++) begin
                            word     = ring[front_ix];
                            front_ix = (front_ix + RING_DEPTH - 1) % RING_DEPTH;
                            rear_ix  = (rear_ix + RING_DEPTH - 1) % RING_DEPTH;
                            ring[rear_ix] = word;
                        end
                    end
                    add_result(ST_OK, '0, 1'b1);
                end
                default: begin
                    add_result(ST_OK, '0, 1'b1);
                end
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] data,
                                   logic last, logic [ENTRIES_W-1:0] entries);
            deque_result_t want;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: status=%0d data=%h last=%b entries=%0d",
                             status, data, last, entries);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || data !== want.data || last !== want.last ||
                entries !== want.entries) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display({"result mismatch: expected status=%0d data=%h last=%b entries=%0d,",
                              " got status=%0d data=%h last=%b entries=%0d"},
                             want.status, want.data, want.last, want.entries,
                             status, data, last, entries);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [3:0]               i_operation = '0;
    logic [VALUE_W-1:0]       i_push_value = '0;
    logic signed [AMT_W-1:0]  i_rotate_amount = '0;
    logic                     o_strobe;
    logic [STATUS_W-1:0]      o_status;
    logic [VALUE_W-1:0]       o_data_out;
    logic                     o_last;
    logic [ENTRIES_W-1:0]     o_entries;

    deque_shadow shadow = new();
    bit          idle_on;

    circular_deque_engine #(
        .DEPTH      (RING_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_push_value    (i_push_value),
        .i_rotate_amount (i_rotate_amount),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_data_out      (o_data_out),
        .o_last          (o_last),
        .o_entries       (o_entries)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            shadow.check_result(o_status, o_data_out, o_last, o_entries);
    end

    // Issue one command, hold it until the transfer, then maybe idle for a burst
    task automatic send_cmd(t_opcode op, logic [VALUE_W-1:0] value,
                            logic signed [AMT_W-1:0] amount);
        start           <= 1'b1;
        i_operation     <= op;
        i_push_value    <= value;
        i_rotate_amount <= amount;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shadow.note_command(op, value, amount);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Hold off new commands until every predicted result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        int                       mode;
        int                       seg_left;
        int                       roll;
        int                       waited;
        int                       t_push, t_pop, t_peek, t_walk, t_rot;
        t_opcode                  op;
        t_opcode                  first_unknown;
        logic [VALUE_W-1:0]       value;
        logic signed [AMT_W-1:0]  amount;

        first_unknown = t_opcode'(int'(OP_ROTATE) + 1);
        idle_on       = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: every empty refusal, walks, rotation and unknown codes
        send_cmd(OP_POP_FRONT, '0, '0);
        send_cmd(OP_POP_REAR, '0, '0);
        send_cmd(OP_PEEK_FRONT, '0, '0);
        send_cmd(OP_PEEK_REAR, '0, '0);
        send_cmd(OP_WALK_FWD, '0, '0);
        send_cmd(OP_WALK_BACK, '0, '0);
        send_cmd(OP_ROTATE, '0, 16'sd5);
        send_cmd(OP_NOP, '1, '1);
        send_cmd(first_unknown, '0, '0);

        // Few elements: extreme data, walks both ways, extreme rotations
        send_cmd(OP_PUSH_FRONT, '0, '0);
        send_cmd(OP_PUSH_REAR, 32'hFFFF_FFFF, '0);
        send_cmd(OP_PUSH_FRONT, 32'hA5A5_5A5A, '0);
        send_cmd(OP_PUSH_REAR, 32'h0000_0001, '0);
        send_cmd(OP_WALK_FWD, '0, '0);
        send_cmd(OP_WALK_BACK, '0, '0);
        send_cmd(OP_ROTATE, '0, 16'sd1);
        send_cmd(OP_ROTATE, '0, -16'sd1);
        send_cmd(OP_ROTATE, '0, 16'sh7FFF);
        send_cmd(OP_ROTATE, '0, 16'sh8000);
        send_cmd(OP_ROTATE, '0, '0);
        send_cmd(OP_PEEK_FRONT, '0, '0);
        send_cmd(OP_PEEK_REAR, '0, '0);
        send_cmd(OP_POP_FRONT, '0, '0);
        send_cmd(OP_POP_REAR, '0, '0);
        send_cmd(OP_WALK_FWD, '0, '0);
        wait_drained();

        // Random segments biased to fill, drain or mix the queue
        seg_left = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(12, 36);
                idle_on  = ($urandom_range(0, 3) != 0);
                if (n < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 4) == 0)
                    wait_drained();
            end
            seg_left--;
            if (n >= RAND_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;

            case (mode)
                0:       begin t_push = 70; t_pop = 80; t_peek = 87; t_walk = 92; t_rot = 98; end
                1:       begin t_push = 15; t_pop = 70; t_peek = 80; t_walk = 87; t_rot = 96; end
                default: begin t_push = 35; t_pop = 65; t_peek = 77; t_walk = 87; t_rot = 96; end
            endcase

            roll = $urandom_range(0, 99);
            if (roll < t_push)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else if (roll < t_pop)
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            else if (roll < t_peek)
                op = $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_REAR;
            else if (roll < t_walk)
                op = $urandom_range(0, 1) ? OP_WALK_FWD : OP_WALK_BACK;
            else if (roll < t_rot)
                op = OP_ROTATE;
            else
                op = t_opcode'($urandom_range(int'(OP_ROTATE) + 1, int'(OP_NOP)));

            case ($urandom_range(0, 9))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            // Half small signed amounts, the other half anywhere in range
            amount = $urandom_range(0, 1) ? AMT_W'($urandom)
                                          : AMT_W'($urandom_range(0, 80) - 40);
            send_cmd(op, value, amount);
        end

        // Drain the tail, then let the back end settle
        start <= 1'b0;
        waited = 0;
        while (shadow.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        shadow.error_count += shadow.outstanding();

        if (shadow.error_count == 0)
            $display("tb_circular_deque_engine: done, clean");
        else
            $display("tb_circular_deque_engine: done, errors");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("tb_circular_deque_engine: done, errors");
        $finish;
    end

endmodule
